// ----- sv/ple_pkg.sv -----
// Shared constants, codes and widths for the positional list engine.
package ple_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int POS_W    = 5;
    localparam int STAT_W   = 2;
    localparam int CMP_W    = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

endpackage

// ----- sv/ple_store.sv -----
// Entry memory: one write port and one read port with registered read data.
module ple_store (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ple_pkg::ADDR_W-1:0]  waddr,
    input  logic [ple_pkg::DATA_W-1:0]  wdata,
    input  logic [ple_pkg::ADDR_W-1:0]  raddr,
    output logic [ple_pkg::DATA_W-1:0]  rdata
);
    import ple_pkg::*;

    logic [DATA_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/positional_list_engine.sv -----
// Top level of the positional list engine: command decode, shift and scan sequencer.
//
//   channel   | beat marked by      | fields
//   ----------+---------------------+---------------------------------------
//   command   | start && !busy      | command, position, value
//   result    | done (one cycle)    | status, result_position, entry_count
//
// Every command gives one result beat. A rejected command is answered from IDLE;
// an insert at the tail goes to INS_VAL, one that moves entries through SHIFT_UP,
// INS_WAIT and INS_VAL, a delete that moves entries through SHIFT_DN, a search
// through SCAN. Each entry moved or compared is read through the single read port
// of the entry memory. Reset empties the list at once; no clearing pass is needed.
// Results cannot be held off: done is a one-cycle strobe, and busy falls in the
// same cycle so the next command may be taken while the result is shown.
module positional_list_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ple_pkg::CMD_W-1:0]           command,
    input  logic [ple_pkg::POS_W-1:0]           position,
    input  logic signed [ple_pkg::DATA_W-1:0]   value,
    output logic                                done,
    output logic [ple_pkg::STAT_W-1:0]          status,
    output logic [ple_pkg::POS_W-1:0]           result_position,
    output logic [ple_pkg::POS_W-1:0]           entry_count
);
    import ple_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        SHIFT_UP,
        INS_WAIT,
        INS_VAL,
        SHIFT_DN,
        SCAN
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] s_reg, s_next;
    logic [COUNT_W-1:0] p_reg, p_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [COUNT_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic               done_reg, done_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [COUNT_W-1:0] rpos_reg, rpos_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [DATA_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [DATA_W-1:0]  mem_rdata;

    logic [COUNT_W-1:0] s_inc, s_dec, count_dec;
    logic [COUNT_W-1:0] p_dec, cmp_idx_inc;
    logic [CMP_W-1:0]   pos_ext, count_ext;
    logic [COUNT_W-1:0] del_p;
    logic               hit;

    ple_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_inc       = s_reg + COUNT_W'(1);
    assign s_dec       = s_reg - COUNT_W'(1);
    assign count_dec   = count_reg - COUNT_W'(1);
    assign p_dec       = p_reg - COUNT_W'(1);
    assign cmp_idx_inc = cmp_idx_reg + COUNT_W'(1);
    assign pos_ext     = CMP_W'(position);
    assign count_ext   = CMP_W'(count_reg);
    assign del_p       = (position == '0) ? COUNT_W'(1) : COUNT_W'(position);
    assign hit         = cmp_valid_reg && (mem_rdata == val_reg);

    assign mem_raddr = s_reg[ADDR_W-1:0];

    // A pending move always owns the write port; the new value goes in afterward.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = mem_rdata;
        if (pend_reg)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == INS_VAL)
        begin
            mem_we    = 1'b1;
            mem_waddr = p_dec[ADDR_W-1:0];
            mem_wdata = val_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        s_next         = s_reg;
        p_next         = p_reg;
        val_next       = val_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        rpos_next      = rpos_reg;

        unique case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    val_next = value;
                    priority if (command == CMD_INSERT)
                    begin
                        if (count_ext >= CMP_W'(CAPACITY))
                        begin
                            done_next   = 1'b1;
                            status_next = ST_FULL;
                            rpos_next   = '0;
                        end
                        else if (pos_ext == '0 || pos_ext > count_ext + CMP_W'(1))
                        begin
                            done_next   = 1'b1;
                            status_next = ST_MISS;
                            rpos_next   = '0;
                        end
                        else
                        begin
                            p_next = COUNT_W'(position);
                            if (pos_ext == count_ext + CMP_W'(1))
                            begin
                                state_next = INS_VAL;
                            end
                            else
                            begin
                                s_next     = count_dec;
                                state_next = SHIFT_UP;
                            end
                        end
                    end
                    else if (command == CMD_SEARCH)
                    begin
                        s_next     = '0;
                        state_next = SCAN;
                    end
                    else if (command == CMD_DELETE)
                    begin
                        if (CMP_W'(del_p) > count_ext || pos_ext > count_ext)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_MISS;
                            rpos_next   = '0;
                        end
                        else if (del_p == count_reg)
                        begin
                            count_next  = count_dec;
                            done_next   = 1'b1;
                            status_next = ST_DONE;
                            rpos_next   = del_p;
                        end
                        else
                        begin
                            p_next     = del_p;
                            s_next     = del_p;
                            state_next = SHIFT_DN;
                        end
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = ST_MISS;
                        rpos_next   = '0;
                    end
                end
            end

            // Read entry s and write it one place higher in the next cycle.
            SHIFT_UP:
            begin
                pend_next      = 1'b1;
                pend_addr_next = s_inc[ADDR_W-1:0];
                if (s_reg == p_dec)
                begin
                    state_next = INS_WAIT;
                end
                else
                begin
                    s_next = s_dec;
                end
            end

            INS_WAIT:
            begin
                state_next = INS_VAL;
            end

            INS_VAL:
            begin
                count_next  = count_reg + COUNT_W'(1);
                done_next   = 1'b1;
                status_next = ST_DONE;
                rpos_next   = p_reg;
                state_next  = IDLE;
            end

            // Read entry s and write it one place lower; the last write lands in IDLE.
            SHIFT_DN:
            begin
                pend_next      = 1'b1;
                pend_addr_next = s_dec[ADDR_W-1:0];
                if (s_reg == count_dec)
                begin
                    count_next  = count_dec;
                    done_next   = 1'b1;
                    status_next = ST_DONE;
                    rpos_next   = p_reg;
                    state_next  = IDLE;
                end
                else
                begin
                    s_next = s_inc;
                end
            end

            SCAN:
            begin
                if (hit)
                begin
                    done_next   = 1'b1;
                    status_next = ST_DONE;
                    rpos_next   = cmp_idx_inc;
                    state_next  = IDLE;
                end
                else if (s_reg == count_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_MISS;
                    rpos_next   = '0;
                    state_next  = IDLE;
                end
                else
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = s_reg;
                    s_next         = s_inc;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg         <= s_next;
        p_reg         <= p_next;
        val_reg       <= val_next;
        pend_addr_reg <= pend_addr_next;
        cmp_idx_reg   <= cmp_idx_next;
        status_reg    <= status_next;
        rpos_reg      <= rpos_next;
    end

    assign busy            = (state_reg != IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign result_position = POS_W'(rpos_reg);
    assign entry_count     = POS_W'(count_reg);

    // A taken command either keeps the engine busy or answers in the next cycle.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command neither in progress nor answered");

    // The list never holds more than its capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // A full report only comes from a full list.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (CMP_W'(count_reg) == CMP_W'(CAPACITY)))
        else $error("full status with room left");

    // The new value and a pending move never compete for the write port.
    a_port_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == INS_VAL) |-> !pend_reg)
        else $error("write port conflict on insert");

    // A successful insert grows the list by exactly one.
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == INS_VAL) |=> (count_reg == $past(count_reg) + COUNT_W'(1)))
        else $error("insert did not grow the list");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the positional list engine.
`timescale 1ns / 100ps

module testbench;
    import ple_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  count;
    } outcome_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [CMD_W-1:0]         command = '0;
    logic [POS_W-1:0]         position = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     done;
    logic [STAT_W-1:0]        status;
    logic [POS_W-1:0]         result_position;
    logic [POS_W-1:0]         entry_count;

    // Mirror of the list contents, updated when a command beat is taken.
    logic signed [DATA_W-1:0] list_q [CAPACITY];
    int unsigned              list_len = 0;
    outcome_t                 outcome_q [$];
    int unsigned              mismatch_count = 0;
    bit                       idle_on = 1'b1;
    bit                       grow_list = 1'b1;

    always #(HALF_PERIOD) clk = ~clk;

    positional_list_engine u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .position        (position),
        .value           (value),
        .done            (done),
        .status          (status),
        .result_position (result_position),
        .entry_count     (entry_count)
    );

    function automatic outcome_t apply_command(input logic [CMD_W-1:0] cmd,
                                               input logic [POS_W-1:0] pos,
                                               input logic signed [DATA_W-1:0] val);
        outcome_t o;
        int       p;
        int       i;
        bit       found;
        o.status   = ST_MISS;
        o.position = '0;
        p          = int'(pos);
        found      = 1'b0;
        case (cmd)
            CMD_INSERT:
                if (list_len >= CAPACITY) begin
                    o.status = ST_FULL;
                end
                else if (p >= 1 && p <= list_len + 1) begin
                    for (i = list_len; i >= p; i--)
                        list_q[i] = list_q[i - 1];
                    list_q[p - 1] = val;
                    list_len++;
                    o.status   = ST_DONE;
                    o.position = pos;
                end
            CMD_SEARCH:
                for (i = 0; i < list_len; i++) begin
                    if (!found && list_q[i] == val) begin
                        found      = 1'b1;
                        o.status   = ST_DONE;
                        o.position = POS_W'(i + 1);
                    end
                end
            CMD_DELETE: begin
                // Position zero takes the head, just as position one does.
                if (p == 0)
                    p = 1;
                if (p <= list_len) begin
                    for (i = p - 1; i + 1 < list_len; i++)
                        list_q[i] = list_q[i + 1];
                    list_len--;
                    o.status   = ST_DONE;
                    o.position = POS_W'(p);
                end
            end
            default: ;
        endcase
        o.count = POS_W'(list_len);
        return o;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endtask

    // Every result beat is compared with the oldest prediction.
    always @(posedge clk) begin
        outcome_t exp_o;
        if (rst_n && done) begin
            if (outcome_q.size() == 0) begin
                note_mismatch($sformatf("unexpected result: status %0d pos %0d count %0d",
                                        status, result_position, entry_count));
            end
            else begin
                exp_o = outcome_q.pop_front();
                if (status !== exp_o.status || result_position !== exp_o.position ||
                    entry_count !== exp_o.count)
                    note_mismatch($sformatf(
                        "result mismatch: expected status %0d pos %0d count %0d, got %0d %0d %0d",
                        exp_o.status, exp_o.position, exp_o.count,
                        status, result_position, entry_count));
            end
        end
    end

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic signed [DATA_W-1:0] val);
        @(negedge clk);
        start    <= 1'b1;
        command  <= cmd;
        position <= pos;
        value    <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        outcome_q.push_back(apply_command(cmd, pos, val));
    endtask

    // Start stays low for the given number of cycles while the fields carry noise.
    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            start    <= 1'b0;
            command  <= CMD_W'($urandom);
            position <= POS_W'($urandom);
            value    <= $urandom;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (outcome_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                         input logic signed [DATA_W-1:0] val);
        if (idle_on && $urandom_range(0, 2) == 0)
            hold_off($urandom_range(1, 16));
        send_beat(cmd, pos, val);
    endtask

    task automatic issue_random();
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        int                       r;
        r   = $urandom_range(0, 99);
        pos = POS_W'($urandom);
        if ($urandom_range(0, 1) == 0) begin
            val = $urandom;
        end
        else begin
            // A small pool of values gives duplicates, so search must find the first one.
            val = $urandom_range(0, 7);
            val = val - 4;
        end
        if (list_len >= CAPACITY)
            grow_list = 1'b0;
        else if (list_len == 0)
            grow_list = 1'b1;
        else if ($urandom_range(0, 49) == 0)
            grow_list = ~grow_list;

        if (r < 10) begin
            cmd = CMD_W'($urandom);
        end
        else if (r < 30) begin
            cmd = CMD_SEARCH;
            if (list_len > 0 && $urandom_range(0, 3) != 0)
                val = list_q[ADDR_W'($urandom_range(0, list_len - 1))];
        end
        else if ((r < 75) == grow_list) begin
            cmd = CMD_INSERT;
            pos = POS_W'($urandom_range(1, list_len + 1));
        end
        else begin
            cmd = CMD_DELETE;
            if (list_len > 0)
                pos = POS_W'($urandom_range(0, list_len));
        end
        issue(cmd, pos, val);
    endtask

    task automatic test_directed_edges();
        send_beat(CMD_SEARCH, 5'd0, 32'sd0);
        send_beat(CMD_DELETE, 5'd0, 32'sd0);
        send_beat(CMD_DELETE, 5'd31, 32'sd0);
        send_beat(CMD_INSERT, 5'd0, 32'sd5);
        send_beat(CMD_INSERT, 5'd2, 32'sd5);
        send_beat(CMD_INSERT, 5'd1, 32'sh8000_0000);
        send_beat(CMD_INSERT, 5'd2, 32'sh7fff_ffff);
        send_beat(CMD_INSERT, 5'd1, -32'sd1);
        send_beat(CMD_INSERT, 5'd2, 32'sd0);
        send_beat(CMD_INSERT, 5'd31, 32'sd9);
        send_beat(CMD_SEARCH, 5'd31, 32'sh7fff_ffff);
        send_beat(CMD_SEARCH, 5'd0, 32'sh8000_0000);
        send_beat(CMD_SEARCH, 5'd3, 32'sd12345);
        send_beat(CMD_INSERT, 5'd5, 32'sd0);
        send_beat(CMD_SEARCH, 5'd0, 32'sd0);
        send_beat(CMD_UNUSED, 5'd1, -32'sd1);
        send_beat(CMD_DELETE, 5'd0, 32'sd0);
        send_beat(CMD_DELETE, 5'd5, 32'sd0);
        send_beat(CMD_DELETE, 5'd4, 32'sd0);
        send_beat(CMD_DELETE, 5'd2, -32'sd1);
        drain();
    endtask

    task automatic test_full_list();
        while (list_len < CAPACITY)
            issue(CMD_INSERT, POS_W'($urandom_range(1, list_len + 1)), $urandom);
        // A full list reports full even when the position itself is invalid.
        issue(CMD_INSERT, 5'd0, 32'sd1);
        issue(CMD_INSERT, 5'd17, 32'sd1);
        issue(CMD_INSERT, 5'd5, 32'sd1);
        issue(CMD_SEARCH, 5'd0, list_q[CAPACITY - 1]);
        issue(CMD_DELETE, 5'd17, 32'sd0);
        issue(CMD_DELETE, 5'd16, 32'sd0);
        issue(CMD_INSERT, 5'd16, 32'sh5a5a_a5a5);
        issue(CMD_INSERT, 5'd17, 32'sd0);
        while (list_len > 0)
            issue(CMD_DELETE, POS_W'($urandom_range(0, list_len)), 32'sd0);
        drain();
    endtask

    task automatic test_random_traffic(input int items);
        for (int n = 0; n < items; n++) begin
            if (n % 64 == 0)
                idle_on = $urandom_range(0, 2) != 0;
            if (n % 300 == 299)
                drain();
            issue_random();
        end
        drain();
    endtask

    task automatic test_back_to_back(input int items);
        idle_on = 1'b0;
        repeat (items)
            issue_random();
        drain();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_edges();
        test_full_list();
        test_random_traffic(1500);
        test_back_to_back(250);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (outcome_q.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", outcome_q.size()));
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/ple_pkg.sv
sv/ple_store.sv
sv/positional_list_engine.sv
verif/testbench.sv
